/* src/spu_pkg.sv */
// ----------------------------------------------------------------------------
// spu_pkg
// shared widths, register map and reset values for the particle update block
// ----------------------------------------------------------------------------
package spu_pkg;

    // register map, index = byte address / 4
    typedef enum logic [2:0] {
        REG_WEIGHT_MAX  = 3'd0,
        REG_WEIGHT_MIN  = 3'd1,
        REG_TOTAL_STEPS = 3'd2,
        REG_COG_GAIN    = 3'd3,
        REG_SOC_GAIN    = 3'd4,
        REG_CLAMP_MODE  = 3'd5
    } t_reg_idx;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register reset values
    localparam logic [16:0] RST_WEIGHT_MAX  = 17'd47829;
    localparam logic [16:0] RST_WEIGHT_MIN  = 17'd19661;
    localparam logic [15:0] RST_TOTAL_STEPS = 16'd500;
    localparam logic [17:0] RST_COG_GAIN    = 18'd98042;
    localparam logic [17:0] RST_SOC_GAIN    = 18'd98042;
    localparam logic        RST_CLAMP_MODE  = 1'b1;

    // inertia divider: |wmax-wmin| * (d-step) over d
    localparam int INR_NUM_W = 33;
    localparam int INR_DEN_W = 16;

    // wrap divider: overshoot modulo span
    localparam int MOD_NUM_W = 34;
    localparam int MOD_DEN_W = 32;

    // bound flags
    localparam logic [1:0] HIT_NONE  = 2'd0;
    localparam logic [1:0] HIT_BELOW = 2'd1;
    localparam logic [1:0] HIT_ABOVE = 2'd2;

endpackage

/* src/spu_div.sv */
// ----------------------------------------------------------------------------
// spu_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module spu_div #(
    parameter int NUM_W = spu_pkg::INR_NUM_W,
    parameter int DEN_W = spu_pkg::INR_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);

    // stage k holds the partial result after k+1 quotient bits
    logic             r_vld [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    // stage inputs, index 0 is the divider input
    logic             w_vld [NUM_W+1];
    logic [NUM_W-1:0] w_num [NUM_W+1];
    logic [NUM_W-1:0] w_quo [NUM_W+1];
    logic [DEN_W-1:0] w_rem [NUM_W+1];
    logic [DEN_W-1:0] w_den [NUM_W+1];

    assign w_vld[0] = i_valid;
    assign w_num[0] = i_num;
    assign w_quo[0] = '0;
    assign w_rem[0] = '0;
    assign w_den[0] = i_den;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0]   t;
        logic [DEN_W:0]   t_sub;
        logic             ge;
        logic [DEN_W-1:0] n_rem;

        // shift in the next dividend bit and try the subtract
        assign t     = {w_rem[k], w_num[k][NUM_W-1]};
        assign t_sub = t - {1'b0, w_den[k]};
        assign ge    = (t >= {1'b0, w_den[k]});
        assign n_rem = ge ? t_sub[DEN_W-1:0] : t[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_num[k] <= {w_num[k][NUM_W-2:0], 1'b0};
            r_quo[k] <= {w_quo[k][NUM_W-2:0], ge};
            r_rem[k] <= n_rem;
            r_den[k] <= w_den[k];
        end

        assign w_vld[k+1] = r_vld[k];
        assign w_num[k+1] = r_num[k];
        assign w_quo[k+1] = r_quo[k];
        assign w_rem[k+1] = r_rem[k];
        assign w_den[k+1] = r_den[k];
    end

    assign o_valid = w_vld[NUM_W];
    assign o_quo   = w_quo[NUM_W];
    assign o_rem   = w_rem[NUM_W];

endmodule

/* src/swarm_particle_update_top.sv */
// ----------------------------------------------------------------------------
// swarm_particle_update_top
// particle swarm velocity and position update for one coordinate per item
// ----------------------------------------------------------------------------
// Usage: drive one coordinate (step, position, velocity, bests, randoms,
// bounds) with start high; busy is never raised, so an item is taken in
// every cycle that start is high and the block sustains one item per clock.
// Each item returns one result: o_done is high for exactly one cycle with new
// position, new velocity and the bound flag. Results leave in transfer order.
// The pipe holds two bit-serial divider pipelines: 33 stages for the inertia
// weight ramp division and 34 stages for the periodic wrap modulo, plus input,
// product, weight, multiply, sum, saturate and output registers. The receiver
// cannot stall: it must take each result in the cycle it is shown. The
// configuration registers sit on an APB-style port at byte address 4*i; the
// user must write them only while no item is in flight, which the block does
// not enforce; pready is always high. Synchronous active-low reset restores
// the register defaults and clears all stage valid bits; no result is pending
// after reset.
// ----------------------------------------------------------------------------
module swarm_particle_update_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic [15:0]                  i_step_index,
    input  logic signed [31:0]           i_position,
    input  logic signed [31:0]           i_velocity,
    input  logic signed [31:0]           i_personal_best,
    input  logic signed [31:0]           i_neighbour_best,
    input  logic [15:0]                  i_uniform_one,
    input  logic [15:0]                  i_uniform_two,
    input  logic signed [31:0]           i_lower_bound,
    input  logic signed [31:0]           i_upper_bound,
    // result channel
    output logic                         o_done,
    output logic signed [31:0]           o_new_position,
    output logic signed [31:0]           o_new_velocity,
    output logic [1:0]                   o_bound_hit,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spu_pkg::ADDR_W-1:0]   paddr,
    input  logic [spu_pkg::DATA_W-1:0]   pwdata,
    output logic [spu_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int INR_W = spu_pkg::INR_NUM_W;
    localparam int MOD_W = spu_pkg::MOD_NUM_W;
    localparam int LAT   = 2 + INR_W + 4 + MOD_W + 1;

    // payload carried beside the inertia divider
    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [32:0] d1;
        logic signed [32:0] d2;
        logic [17:0]        rho1;
        logic [17:0]        rho2;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               en;
        logic               neg;
    } t_inr_pl;

    // payload carried beside the wrap divider
    typedef struct packed {
        logic [31:0]        sum;
        logic signed [31:0] nv;
        logic [31:0]        lo;
        logic [31:0]        hi;
        logic [1:0]         hit;
        logic               empty;
    } t_mod_pl;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [16:0] r_weight_max;
    logic [16:0] r_weight_min;
    logic [15:0] r_total_steps;
    logic [17:0] r_cog_gain;
    logic [17:0] r_soc_gain;
    logic        r_clamp_mode;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite && pready;

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_max  <= spu_pkg::RST_WEIGHT_MAX;
            r_weight_min  <= spu_pkg::RST_WEIGHT_MIN;
            r_total_steps <= spu_pkg::RST_TOTAL_STEPS;
            r_cog_gain    <= spu_pkg::RST_COG_GAIN;
            r_soc_gain    <= spu_pkg::RST_SOC_GAIN;
            r_clamp_mode  <= spu_pkg::RST_CLAMP_MODE;
        end else if (cfg_wr) begin
            unique case (spu_pkg::t_reg_idx'(paddr[4:2]))
                spu_pkg::REG_WEIGHT_MAX:  r_weight_max  <= pwdata[16:0];
                spu_pkg::REG_WEIGHT_MIN:  r_weight_min  <= pwdata[16:0];
                spu_pkg::REG_TOTAL_STEPS: r_total_steps <= pwdata[15:0];
                spu_pkg::REG_COG_GAIN:    r_cog_gain    <= pwdata[17:0];
                spu_pkg::REG_SOC_GAIN:    r_soc_gain    <= pwdata[17:0];
                spu_pkg::REG_CLAMP_MODE:  r_clamp_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb begin
        unique case (spu_pkg::t_reg_idx'(paddr[4:2]))
            spu_pkg::REG_WEIGHT_MAX:  prdata = {15'd0, r_weight_max};
            spu_pkg::REG_WEIGHT_MIN:  prdata = {15'd0, r_weight_min};
            spu_pkg::REG_TOTAL_STEPS: prdata = {16'd0, r_total_steps};
            spu_pkg::REG_COG_GAIN:    prdata = {14'd0, r_cog_gain};
            spu_pkg::REG_SOC_GAIN:    prdata = {14'd0, r_soc_gain};
            spu_pkg::REG_CLAMP_MODE:  prdata = {31'd0, r_clamp_mode};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    logic               r_s1_vld;
    logic [15:0]        r_s1_step;
    logic signed [31:0] r_s1_pos;
    logic signed [31:0] r_s1_vel;
    logic signed [31:0] r_s1_pb;
    logic signed [31:0] r_s1_nb;
    logic [15:0]        r_s1_r1;
    logic [15:0]        r_s1_r2;
    logic signed [31:0] r_s1_lo;
    logic signed [31:0] r_s1_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_step <= i_step_index;
        r_s1_pos  <= i_position;
        r_s1_vel  <= i_velocity;
        r_s1_pb   <= i_personal_best;
        r_s1_nb   <= i_neighbour_best;
        r_s1_r1   <= i_uniform_one;
        r_s1_r2   <= i_uniform_two;
        r_s1_lo   <= i_lower_bound;
        r_s1_hi   <= i_upper_bound;
    end

    // ramp length, weight span and random gain products
    logic [17:0] s1_d3;
    logic [15:0] s1_d;
    logic        s1_en;
    logic [15:0] s1_ds;
    logic [17:0] s1_wdiff;
    logic [17:0] s1_wneg;
    logic [16:0] s1_wmag;
    logic [33:0] s1_rp1;
    logic [33:0] s1_rp2;

    assign s1_d3    = {1'b0, r_total_steps, 1'b0} + {2'b0, r_total_steps};
    assign s1_d     = s1_d3[17:2];
    assign s1_en    = (s1_d != 16'd0) && (r_s1_step <= s1_d);
    assign s1_ds    = s1_d - r_s1_step;
    assign s1_wdiff = {1'b0, r_weight_max} - {1'b0, r_weight_min};
    assign s1_wneg  = -s1_wdiff;
    assign s1_wmag  = s1_wdiff[17] ? s1_wneg[16:0] : s1_wdiff[16:0];
    assign s1_rp1   = {16'd0, r_cog_gain} * {18'd0, r_s1_r1};
    assign s1_rp2   = {16'd0, r_soc_gain} * {18'd0, r_s1_r2};

    // ------------------------------------------------------------------
    // stage 2: ramp product and random gains
    // ------------------------------------------------------------------
    logic              r_s2_vld;
    logic [INR_W-1:0]  r_s2_prod;
    logic [15:0]       r_s2_d;
    t_inr_pl           r_s2_pl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_prod       <= INR_W'({16'd0, s1_wmag} * {17'd0, s1_ds});
        r_s2_d          <= s1_d;
        r_s2_pl.pos     <= r_s1_pos;
        r_s2_pl.vel     <= r_s1_vel;
        r_s2_pl.d1      <= 33'(r_s1_pb) - 33'(r_s1_pos);
        r_s2_pl.d2      <= 33'(r_s1_nb) - 33'(r_s1_pos);
        r_s2_pl.rho1    <= s1_rp1[33:16];
        r_s2_pl.rho2    <= s1_rp2[33:16];
        r_s2_pl.lo      <= r_s1_lo;
        r_s2_pl.hi      <= r_s1_hi;
        r_s2_pl.en      <= s1_en;
        r_s2_pl.neg     <= s1_wdiff[17];
    end

    // ------------------------------------------------------------------
    // inertia divider and matching payload delay
    // ------------------------------------------------------------------
    logic             inr_vld;
    logic [INR_W-1:0] inr_quo;
    logic [15:0]      inr_rem;
    t_inr_pl          r_dl1 [INR_W];

    spu_div #(
        .NUM_W (spu_pkg::INR_NUM_W),
        .DEN_W (spu_pkg::INR_DEN_W)
    ) u_inr_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_vld),
        .i_num   (r_s2_prod),
        .i_den   (r_s2_d),
        .o_valid (inr_vld),
        .o_quo   (inr_quo),
        .o_rem   (inr_rem)
    );

    always_ff @(posedge i_clk) begin
        r_dl1[0] <= r_s2_pl;
        for (int i = 1; i < INR_W; i++) begin
            r_dl1[i] <= r_dl1[i-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: inertia weight
    // ------------------------------------------------------------------
    logic        r_s3_vld;
    logic [16:0] r_s3_w;
    t_inr_pl     r_s3_pl;
    logic [16:0] s3_q;

    // quotient does not exceed the weight span while the ramp is active; remainder is not needed
    assign s3_q = inr_quo[16:0] | 17'(inr_rem & 16'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= inr_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_pl <= r_dl1[INR_W-1];
        if (!r_dl1[INR_W-1].en) begin
            r_s3_w <= r_weight_min;
        end else if (r_dl1[INR_W-1].neg) begin
            r_s3_w <= r_weight_min - s3_q;
        end else begin
            r_s3_w <= r_weight_min + s3_q;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: three products
    // ------------------------------------------------------------------
    logic               r_s4_vld;
    logic signed [51:0] r_s4_p0;
    logic signed [51:0] r_s4_p1;
    logic signed [51:0] r_s4_p2;
    logic signed [31:0] r_s4_pos;
    logic signed [31:0] r_s4_lo;
    logic signed [31:0] r_s4_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_p0  <= 52'($signed({1'b0, r_s3_w}) * r_s3_pl.vel);
        r_s4_p1  <= 52'($signed({1'b0, r_s3_pl.rho1}) * r_s3_pl.d1);
        r_s4_p2  <= 52'($signed({1'b0, r_s3_pl.rho2}) * r_s3_pl.d2);
        r_s4_pos <= r_s3_pl.pos;
        r_s4_lo  <= r_s3_pl.lo;
        r_s4_hi  <= r_s3_pl.hi;
    end

    // ------------------------------------------------------------------
    // stage 5: accumulate with 16 fraction bits
    // ------------------------------------------------------------------
    logic               r_s5_vld;
    logic signed [53:0] r_s5_acc;
    logic signed [31:0] r_s5_pos;
    logic signed [31:0] r_s5_lo;
    logic signed [31:0] r_s5_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_acc <= 54'(r_s4_p0) + 54'(r_s4_p1) + 54'(r_s4_p2);
        r_s5_pos <= r_s4_pos;
        r_s5_lo  <= r_s4_lo;
        r_s5_hi  <= r_s4_hi;
    end

    // ------------------------------------------------------------------
    // stage 6: floor, saturate, move and bound check
    // ------------------------------------------------------------------
    logic signed [37:0] s6_sh;
    logic signed [31:0] s6_nv;
    logic signed [32:0] s6_sum;
    logic               s6_below;
    logic               s6_above;
    logic signed [33:0] s6_ovr_lo;
    logic signed [33:0] s6_ovr_hi;
    logic signed [32:0] s6_span;

    // arithmetic shift is the floor toward minus infinity
    assign s6_sh = r_s5_acc[53:16];

    always_comb begin
        if (s6_sh > 38'sd2147483647) begin
            s6_nv = 32'sh7fffffff;
        end else if (s6_sh < -38'sd2147483648) begin
            s6_nv = 32'sh80000000;
        end else begin
            s6_nv = s6_sh[31:0];
        end
    end

    assign s6_sum    = 33'(r_s5_pos) + 33'(s6_nv);
    assign s6_below  = s6_sum < 33'(r_s5_lo);
    assign s6_above  = s6_sum > 33'(r_s5_hi);
    assign s6_ovr_lo = 34'(r_s5_lo) - 34'(s6_sum);
    assign s6_ovr_hi = 34'(s6_sum) - 34'(r_s5_hi);
    assign s6_span   = 33'(r_s5_hi) - 33'(r_s5_lo);

    logic             r_s6_vld;
    logic [MOD_W-1:0] r_s6_ovr;
    logic [31:0]      r_s6_span;
    t_mod_pl          r_s6_pl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else begin
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_ovr      <= s6_below ? s6_ovr_lo : s6_ovr_hi;
        r_s6_span     <= s6_span[31:0];
        r_s6_pl.sum   <= s6_sum[31:0];
        r_s6_pl.nv    <= s6_nv;
        r_s6_pl.lo    <= r_s5_lo;
        r_s6_pl.hi    <= r_s5_hi;
        r_s6_pl.empty <= (r_s5_hi <= r_s5_lo);
        if (s6_below) begin
            r_s6_pl.hit <= spu_pkg::HIT_BELOW;
        end else if (s6_above) begin
            r_s6_pl.hit <= spu_pkg::HIT_ABOVE;
        end else begin
            r_s6_pl.hit <= spu_pkg::HIT_NONE;
        end
    end

    // ------------------------------------------------------------------
    // wrap divider and matching payload delay
    // ------------------------------------------------------------------
    logic             mod_vld;
    logic [MOD_W-1:0] mod_quo;
    logic [31:0]      mod_rem;
    t_mod_pl          r_dl2 [MOD_W];

    spu_div #(
        .NUM_W (spu_pkg::MOD_NUM_W),
        .DEN_W (spu_pkg::MOD_DEN_W)
    ) u_mod_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s6_vld),
        .i_num   (r_s6_ovr),
        .i_den   (r_s6_span),
        .o_valid (mod_vld),
        .o_quo   (mod_quo),
        .o_rem   (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        r_dl2[0] <= r_s6_pl;
        for (int i = 1; i < MOD_W; i++) begin
            r_dl2[i] <= r_dl2[i-1];
        end
    end

    // ------------------------------------------------------------------
    // output stage: clamp or wrap, zero velocity on a bound hit
    // ------------------------------------------------------------------
    t_mod_pl     fin;
    logic [31:0] fin_pos;

    assign fin = r_dl2[MOD_W-1];

    // quotient is dropped, only the remainder feeds the wrap
    always_comb begin
        if (fin.empty) begin
            fin_pos = fin.lo;
        end else if (fin.hit == spu_pkg::HIT_BELOW) begin
            fin_pos = r_clamp_mode ? fin.lo : fin.hi - mod_rem;
        end else if (fin.hit == spu_pkg::HIT_ABOVE) begin
            fin_pos = r_clamp_mode ? fin.hi : fin.lo + mod_rem;
        end else begin
            fin_pos = fin.sum | 32'(mod_quo & '0);
        end
    end

    logic               r_done;
    logic signed [31:0] r_new_pos;
    logic signed [31:0] r_new_vel;
    logic [1:0]         r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= mod_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new_pos <= fin_pos;
        r_new_vel <= (fin.hit != spu_pkg::HIT_NONE) ? 32'sd0 : fin.nv;
        r_hit     <= fin.hit;
    end

    assign o_done         = r_done;
    assign o_new_position = r_new_pos;
    assign o_new_velocity = r_new_vel;
    assign o_bound_hit    = r_hit;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // every registered item reaches the result strobe after the full pipe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> ##(LAT - 1) o_done)
        else $error("item lost in pipeline");

    // inertia weight stays between the two configured weights
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |-> ((r_s3_w >= r_weight_min && r_s3_w <= r_weight_max) ||
                      (r_s3_w <= r_weight_min && r_s3_w >= r_weight_max)))
        else $error("inertia weight out of range");

    // a bound hit always returns zero velocity
    a_hit_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bound_hit != spu_pkg::HIT_NONE) |-> (o_new_velocity == 32'sd0))
        else $error("velocity not zeroed on bound hit");

    // the bound flag never takes the unused code
    a_hit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_bound_hit != 2'd3))
        else $error("bad bound flag");

endmodule
